>>> rtl/core/assert_macros.svh
// Assertion helper macros for the sparse row matrix-vector engine.
// Used by RTL files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SRME_AST_IMP(lbl, c, r, a, b, msg) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |-> (b)) else $error(msg);

// next-cycle implication
`define SRME_AST_NXT(lbl, c, r, a, b, msg) \
	lbl: assert property (@(posedge c) disable iff (!r) (a) |=> (b)) else $error(msg);

`endif

>>> rtl/core/srme_pkg.sv
// Shared types and constants for the sparse row matrix-vector engine.
// No dependencies.
package srme_pkg;

	localparam int LANES  = 4;
	localparam int LANE_W = 2;
	localparam int SUM_W  = 40;

	localparam logic [1:0] CMD_WLOAD   = 2'd0;
	localparam logic [1:0] CMD_HLOAD   = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;
	localparam logic [1:0] CMD_READ    = 2'd3;

	localparam logic REG_INPUT_WIDTH  = 1'b0;
	localparam logic REG_OUTPUT_WIDTH = 1'b1;

	typedef struct packed {
		logic vld;
		logic first;
		logic done;
	} ctl_t;

	typedef struct packed {
		logic              we;
		logic [LANE_W-1:0] bank;
	} wld_t;

endpackage

>>> rtl/core/srme_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srme_ram #(
	parameter int W = 16,
	parameter int D = 256
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0]   waddr,
	input  logic [W-1:0]                         wdata,
	input  logic [(D > 1 ? $clog2(D) : 1)-1:0]   raddr,
	output logic [W-1:0]                         rdata
);
	logic [W-1:0] mem [0:D-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

>>> rtl/core/srme_cell.sv
// One multiply-accumulate cell of the dot-product chain; owns one weight bank.
// Depends on srme_pkg and srme_ram.
module srme_cell #(
	parameter int K       = 0,
	parameter int IN_MAX  = 256,
	parameter int OUT_MAX = 256,
	parameter int POS_MAX = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  srme_pkg::ctl_t         ctl_i,
	input  logic [(((OUT_MAX+3)/4) > 1 ? $clog2((OUT_MAX+3)/4) : 1)-1:0] g_i,
	input  logic [(((IN_MAX > 4) ? IN_MAX : 4) > 1 ?
		$clog2((IN_MAX > 4) ? IN_MAX : 4) : 1)-1:0] i_i,
	input  logic [(POS_MAX > 1 ? $clog2(POS_MAX) : 1)-1:0] n_i,
	input  logic signed [15:0]     h_i,
	output srme_pkg::ctl_t         ctl_o,
	output logic [(((OUT_MAX+3)/4) > 1 ? $clog2((OUT_MAX+3)/4) : 1)-1:0] g_o,
	output logic [(((IN_MAX > 4) ? IN_MAX : 4) > 1 ?
		$clog2((IN_MAX > 4) ? IN_MAX : 4) : 1)-1:0] i_o,
	output logic [(POS_MAX > 1 ? $clog2(POS_MAX) : 1)-1:0] n_o,
	output logic signed [15:0]     h_o,
	input  srme_pkg::wld_t         wld,
	input  logic [((((OUT_MAX+3)/4)*IN_MAX) > 1 ?
		$clog2(((OUT_MAX+3)/4)*IN_MAX) : 1)-1:0] wld_addr,
	input  logic signed [15:0]     wld_data,
	input  logic [$clog2(OUT_MAX+1)-1:0] no,
	output logic                   res_we,
	output logic [((POS_MAX*OUT_MAX) > 1 ? $clog2(POS_MAX*OUT_MAX) : 1)-1:0] res_addr,
	output logic signed [srme_pkg::SUM_W-1:0] res_data
);
	import srme_pkg::*;

	localparam int GRP  = (OUT_MAX + LANES - 1) / LANES;
	localparam int G_W  = (GRP > 1) ? $clog2(GRP) : 1;
	localparam int SPN  = (IN_MAX > LANES) ? IN_MAX : LANES;
	localparam int I_W  = (SPN > 1) ? $clog2(SPN) : 1;
	localparam int P_W  = (POS_MAX > 1) ? $clog2(POS_MAX) : 1;
	localparam int WD   = GRP * IN_MAX;
	localparam int WA_W = (WD > 1) ? $clog2(WD) : 1;
	localparam int RD   = POS_MAX * OUT_MAX;
	localparam int RA_W = (RD > 1) ? $clog2(RD) : 1;
	localparam int AW   = 33 + $clog2(IN_MAX + 1);
	localparam int XW   = (AW > SUM_W) ? AW : SUM_W;
	localparam logic signed [SUM_W-1:0] SUM_HI = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_LO = {1'b1, {(SUM_W-1){1'b0}}};

	ctl_t                ctl_s1, ctl_s2, ctl_s3;
	logic [G_W-1:0]      g_s1, g_s2, g_s3;
	logic [I_W-1:0]      i_s1;
	logic [P_W-1:0]      n_s1, n_s2, n_s3;
	logic signed [15:0]  h_s1, h_s2;
	logic signed [31:0]  prod_s3;
	logic signed [15:0]  w_rd;
	logic [WA_W-1:0]     raddr;
	logic signed [AW-1:0] acc_q, sum_c, tot;
	logic signed [XW-1:0] tot_x;
	int                  o;

	assign raddr = ctl_s1.vld ? WA_W'(int'(g_s1) * IN_MAX + int'(i_s1)) : '0;

	srme_ram #(.W(16), .D(WD)) u_wram (
		.clk   (clk),
		.we    (wld.we && wld.bank == LANE_W'(K)),
		.waddr (wld_addr),
		.wdata (wld_data),
		.raddr (raddr),
		.rdata (w_rd)
	);

	assign ctl_o = ctl_s1;
	assign g_o   = g_s1;
	assign i_o   = i_s1;
	assign n_o   = n_s1;
	assign h_o   = h_s1;

	always_comb begin
		o     = int'(g_s3) * LANES + K;
		sum_c = ctl_s3.first ? AW'(prod_s3) : acc_q + AW'(prod_s3);
		tot   = ctl_s3.vld ? sum_c : acc_q;
		tot_x = XW'(tot);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			res_we <= 1'b0;
		end else begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			res_we <= ctl_s3.done && (o < int'(no));
		end
	end

	always_ff @(posedge clk) begin
		g_s1    <= g_i;
		i_s1    <= i_i;
		n_s1    <= n_i;
		h_s1    <= h_i;
		g_s2    <= g_s1;
		n_s2    <= n_s1;
		h_s2    <= h_s1;
		g_s3    <= g_s2;
		n_s3    <= n_s2;
		prod_s3 <= 32'(h_s2) * 32'(w_rd);
		if (ctl_s3.vld) begin
			acc_q <= sum_c;
		end
		res_addr <= RA_W'(int'(n_s3) * OUT_MAX + o);
		if (tot_x > XW'(SUM_HI)) begin
			res_data <= SUM_HI;
		end else if (tot_x < XW'(SUM_LO)) begin
			res_data <= SUM_LO;
		end else begin
			res_data <= tot_x[SUM_W-1:0];
		end
	end
endmodule

>>> rtl/core/srme_seq.sv
// Compute sequencer: hidden store, active marks, row scan, clearing pass.
// Depends on srme_pkg and srme_ram.
module srme_seq #(
	parameter int IN_MAX  = 256,
	parameter int OUT_MAX = 256,
	parameter int POS_MAX = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [$clog2(IN_MAX+1)-1:0]  ni,
	input  logic [$clog2(OUT_MAX+1)-1:0] no,
	input  logic                   hid_we,
	input  logic [(POS_MAX > 1 ? $clog2(POS_MAX) : 1)-1:0] hid_pos,
	input  logic [7:0]             hid_dim,
	input  logic signed [15:0]     hid_val,
	output logic                   busy,
	output srme_pkg::ctl_t         ctl_s1,
	output logic [(((OUT_MAX+3)/4) > 1 ? $clog2((OUT_MAX+3)/4) : 1)-1:0] g_s1,
	output logic [(((IN_MAX > 4) ? IN_MAX : 4) > 1 ?
		$clog2((IN_MAX > 4) ? IN_MAX : 4) : 1)-1:0] i_s1,
	output logic [(POS_MAX > 1 ? $clog2(POS_MAX) : 1)-1:0] n_s1,
	output logic signed [15:0]     h,
	output logic [$clog2(OUT_MAX+1)-1:0] no_q,
	output logic [$clog2(OUT_MAX+1)-1:0] lw_q,
	output logic [$clog2(POS_MAX+1)-1:0] count_q,
	output logic                   pl_we,
	output logic [(POS_MAX > 1 ? $clog2(POS_MAX) : 1)-1:0] pl_addr,
	output logic [(POS_MAX > 1 ? $clog2(POS_MAX) : 1)-1:0] pl_data
);
	import srme_pkg::*;

	localparam int GRP   = (OUT_MAX + LANES - 1) / LANES;
	localparam int G_W   = (GRP > 1) ? $clog2(GRP) : 1;
	localparam int SPN   = (IN_MAX > LANES) ? IN_MAX : LANES;
	localparam int I_W   = (SPN > 1) ? $clog2(SPN) : 1;
	localparam int P_W   = (POS_MAX > 1) ? $clog2(POS_MAX) : 1;
	localparam int PC_W  = $clog2(POS_MAX + 1);
	localparam int NI_W  = $clog2(IN_MAX + 1);
	localparam int HD    = POS_MAX * IN_MAX;
	localparam int HA_W  = (HD > 1) ? $clog2(HD) : 1;
	localparam int DRN   = LANES + 6;
	localparam int DR_W  = $clog2(DRN);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLEAR = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_RUN   = 3'd3;
	localparam logic [2:0] ST_DRAIN = 3'd4;

	logic [2:0]         st_q;
	logic [HA_W-1:0]    clr_q;
	logic [POS_MAX-1:0] marks_q;
	logic [PC_W-1:0]    p_q, n_q;
	logic [G_W-1:0]     g_q, glast;
	logic [I_W-1:0]     i_q;
	logic [NI_W-1:0]    ni_q;
	logic [DR_W-1:0]    drn_q;
	logic               i_vld, i_end;
	int                 span;
	logic               h_we;
	logic [HA_W-1:0]    h_waddr, h_raddr;
	logic signed [15:0] h_wdata;

	always_comb begin
		span  = (int'(ni_q) > LANES) ? int'(ni_q) : LANES;
		i_vld = int'(i_q) < int'(ni_q);
		i_end = int'(i_q) == span - 1;
		glast = G_W'((no_q - 1'b1) >> LANE_W);
	end

	assign busy = st_q != ST_IDLE;

	assign h_we    = (st_q == ST_CLEAR) || hid_we;
	assign h_waddr = (st_q == ST_CLEAR) ? clr_q :
		HA_W'(int'(hid_pos) * IN_MAX + int'(hid_dim));
	assign h_wdata = (st_q == ST_CLEAR) ? 16'sd0 : hid_val;
	assign h_raddr = (st_q == ST_RUN && i_vld) ?
		HA_W'(int'(p_q) * IN_MAX + int'(i_q)) : '0;

	srme_ram #(.W(16), .D(HD)) u_hram (
		.clk   (clk),
		.we    (h_we),
		.waddr (h_waddr),
		.wdata (h_wdata),
		.raddr (h_raddr),
		.rdata (h)
	);

	assign pl_we   = (st_q == ST_RUN) && (i_q == '0) && (g_q == '0);
	assign pl_addr = P_W'(n_q);
	assign pl_data = P_W'(p_q);

	always_ff @(posedge clk) begin
		g_s1 <= g_q;
		i_s1 <= i_q;
		n_s1 <= P_W'(n_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_CLEAR;
			clr_q   <= '0;
			marks_q <= '0;
			p_q     <= '0;
			n_q     <= '0;
			g_q     <= '0;
			i_q     <= '0;
			ni_q    <= '0;
			no_q    <= '0;
			lw_q    <= '0;
			count_q <= '0;
			drn_q   <= '0;
			ctl_s1  <= '0;
		end else begin
			ctl_s1 <= '0;
			if (hid_we) begin
				marks_q[hid_pos] <= 1'b1;
			end
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == HA_W'(HD - 1)) begin
						clr_q <= '0;
						st_q  <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						ni_q    <= ni;
						no_q    <= no;
						p_q     <= '0;
						n_q     <= '0;
						count_q <= '0;
						if (ni == '0 || no == '0) begin
							lw_q    <= '0;
							marks_q <= '0;
							st_q    <= ST_CLEAR;
						end else begin
							lw_q <= no;
							st_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (int'(p_q) == POS_MAX) begin
						count_q <= n_q;
						drn_q   <= '0;
						st_q    <= ST_DRAIN;
					end else if (marks_q[P_W'(p_q)]) begin
						g_q  <= '0;
						i_q  <= '0;
						st_q <= ST_RUN;
					end else begin
						p_q <= p_q + 1'b1;
					end
				end
				ST_RUN: begin
					ctl_s1 <= '{vld: i_vld, first: (i_q == '0), done: i_end};
					if (i_end) begin
						i_q <= '0;
						if (g_q == glast) begin
							g_q  <= '0;
							p_q  <= p_q + 1'b1;
							n_q  <= n_q + 1'b1;
							st_q <= ST_SCAN;
						end else begin
							g_q <= g_q + 1'b1;
						end
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					drn_q <= drn_q + 1'b1;
					if (drn_q == DR_W'(DRN - 1)) begin
						marks_q <= '0;
						clr_q   <= '0;
						st_q    <= ST_CLEAR;
					end
				end
				default: begin
					st_q <= ST_CLEAR;
				end
			endcase
		end
	end
endmodule

>>> rtl/core/sparse_row_matvec_engine.sv
// Top level of the sparse row matrix-vector engine: command decode, read-out.
// Depends on srme_pkg, srme_ram, srme_cell, srme_seq and assert_macros.svh.
//
//  channel | signals                       | word
//  item    | item_valid / item_stall       | cmd + weight and hidden fields
//  res     | res_valid / res_stall         | out_position, out_index, sum_value, last, empty_res
//
// Load items write their RAM directly; a read passes stage pend_s1, then its word sits in the
// output register. Compute scans all POS_MAX positions and runs each active row as ceil(W_out/4)
// groups of max(W_in,4) steps through four MAC cells in a chain, one hidden store read per cycle
// while a row runs. A pass clearing all POS_MAX * IN_MAX hidden store words (16384 at default)
// follows reset and each compute; items stall during compute and clearing, configuration writes
// are always taken. A read item stalls while the previous result word has not been taken.
module sparse_row_matvec_engine #(
	parameter int IN_MAX  = 256,
	parameter int OUT_MAX = 256,
	parameter int POS_MAX = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic               wr_index,
	input  logic [8:0]         wr_data,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [1:0]         cmd,
	input  logic [7:0]         weight_row,
	input  logic [7:0]         weight_col,
	input  logic signed [15:0] weight_value,
	input  logic [5:0]         position,
	input  logic [7:0]         dimension,
	input  logic signed [15:0] hidden_value,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [5:0]         out_position,
	output logic [7:0]         out_index,
	output logic signed [39:0] sum_value,
	output logic               last,
	output logic               empty_res
);
	import srme_pkg::*;
	`include "assert_macros.svh"

	localparam int GRP  = (OUT_MAX + LANES - 1) / LANES;
	localparam int G_W  = (GRP > 1) ? $clog2(GRP) : 1;
	localparam int SPN  = (IN_MAX > LANES) ? IN_MAX : LANES;
	localparam int I_W  = (SPN > 1) ? $clog2(SPN) : 1;
	localparam int P_W  = (POS_MAX > 1) ? $clog2(POS_MAX) : 1;
	localparam int PC_W = $clog2(POS_MAX + 1);
	localparam int NI_W = $clog2(IN_MAX + 1);
	localparam int O_W  = $clog2(OUT_MAX + 1);
	localparam int WD   = GRP * IN_MAX;
	localparam int WA_W = (WD > 1) ? $clog2(WD) : 1;
	localparam int RD   = POS_MAX * OUT_MAX;
	localparam int RA_W = (RD > 1) ? $clog2(RD) : 1;

	logic [8:0]        in_w_q, out_w_q;
	logic [NI_W-1:0]   ni_eff;
	logic [O_W-1:0]    no_eff;
	logic              acc_ok, busy, start, rd;
	logic              hid_we;
	wld_t              wld;
	logic [WA_W-1:0]   wld_addr;

	ctl_t               ctl_c [0:LANES];
	logic [G_W-1:0]     g_c   [0:LANES];
	logic [I_W-1:0]     i_c   [0:LANES];
	logic [P_W-1:0]     n_c   [0:LANES];
	logic signed [15:0] h_c   [0:LANES];

	logic [LANES-1:0]        res_we_v;
	logic [RA_W-1:0]         res_addr_a [0:LANES-1];
	logic signed [SUM_W-1:0] res_data_a [0:LANES-1];
	logic                    r_we;
	logic [RA_W-1:0]         r_waddr;
	logic signed [SUM_W-1:0] r_wdata, r_rdata;

	logic [O_W-1:0]    no_q, lw_q;
	logic [PC_W-1:0]   count_q, row_q;
	logic [O_W-1:0]    col_q;
	logic              pl_we;
	logic [P_W-1:0]    pl_addr, pl_data, pl_rdata;
	logic              empty_c, last_c;
	logic              pend_s1, empty_s1, last_s1;
	logic [7:0]        idx_s1;
	logic              res_valid_q;

	assign ni_eff = (int'(in_w_q) > IN_MAX) ? NI_W'(IN_MAX) : NI_W'(in_w_q);
	assign no_eff = (int'(out_w_q) > OUT_MAX) ? O_W'(OUT_MAX) : O_W'(out_w_q);

	assign item_stall = busy || pend_s1 || (res_valid_q && cmd == CMD_READ);
	assign acc_ok     = item_valid && !item_stall;
	assign start      = acc_ok && cmd == CMD_COMPUTE;
	assign rd         = acc_ok && cmd == CMD_READ;

	assign wld.we   = acc_ok && cmd == CMD_WLOAD &&
		int'(weight_row) < OUT_MAX && int'(weight_col) < IN_MAX;
	assign wld.bank = weight_row[LANE_W-1:0];
	assign wld_addr = WA_W'(int'(weight_row >> LANE_W) * IN_MAX + int'(weight_col));
	assign hid_we   = acc_ok && cmd == CMD_HLOAD &&
		int'(position) < POS_MAX && int'(dimension) < int'(ni_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_w_q  <= '0;
			out_w_q <= '0;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_INPUT_WIDTH:  in_w_q  <= wr_data;
				REG_OUTPUT_WIDTH: out_w_q <= wr_data;
				default: ;
			endcase
		end
	end

	srme_seq #(.IN_MAX(IN_MAX), .OUT_MAX(OUT_MAX), .POS_MAX(POS_MAX)) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.ni      (ni_eff),
		.no      (no_eff),
		.hid_we  (hid_we),
		.hid_pos (P_W'(position)),
		.hid_dim (dimension),
		.hid_val (hidden_value),
		.busy    (busy),
		.ctl_s1  (ctl_c[0]),
		.g_s1    (g_c[0]),
		.i_s1    (i_c[0]),
		.n_s1    (n_c[0]),
		.h       (h_c[0]),
		.no_q    (no_q),
		.lw_q    (lw_q),
		.count_q (count_q),
		.pl_we   (pl_we),
		.pl_addr (pl_addr),
		.pl_data (pl_data)
	);

	for (genvar k = 0; k < LANES; k++) begin : g_cell
		srme_cell #(.K(k), .IN_MAX(IN_MAX), .OUT_MAX(OUT_MAX), .POS_MAX(POS_MAX)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl_i    (ctl_c[k]),
			.g_i      (g_c[k]),
			.i_i      (i_c[k]),
			.n_i      (n_c[k]),
			.h_i      (h_c[k]),
			.ctl_o    (ctl_c[k+1]),
			.g_o      (g_c[k+1]),
			.i_o      (i_c[k+1]),
			.n_o      (n_c[k+1]),
			.h_o      (h_c[k+1]),
			.wld      (wld),
			.wld_addr (wld_addr),
			.wld_data (weight_value),
			.no       (no_q),
			.res_we   (res_we_v[k]),
			.res_addr (res_addr_a[k]),
			.res_data (res_data_a[k])
		);
	end

	always_comb begin
		r_we    = |res_we_v;
		r_waddr = '0;
		r_wdata = '0;
		for (int k = 0; k < LANES; k++) begin
			r_waddr = r_waddr | (res_we_v[k] ? res_addr_a[k] : '0);
			r_wdata = r_wdata | (res_we_v[k] ? res_data_a[k] : '0);
		end
	end

	srme_ram #(.W(SUM_W), .D(RD)) u_rram (
		.clk   (clk),
		.we    (r_we),
		.waddr (r_waddr),
		.wdata (r_wdata),
		.raddr (RA_W'(int'(row_q) * OUT_MAX + int'(col_q))),
		.rdata (r_rdata)
	);

	srme_ram #(.W(P_W), .D(POS_MAX)) u_plist (
		.clk   (clk),
		.we    (pl_we),
		.waddr (pl_addr),
		.wdata (pl_data),
		.raddr (P_W'(row_q)),
		.rdata (pl_rdata)
	);

	assign empty_c = (int'(row_q) >= int'(count_q)) || (lw_q == '0);
	assign last_c  = (int'(row_q) + 1 == int'(count_q)) && (int'(col_q) + 1 == int'(lw_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q       <= '0;
			col_q       <= '0;
			pend_s1     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			pend_s1 <= rd;
			if (start) begin
				row_q <= '0;
				col_q <= '0;
			end else if (rd && !empty_c) begin
				if (int'(col_q) + 1 >= int'(lw_q)) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
			if (pend_s1) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			empty_s1 <= empty_c;
			last_s1  <= last_c && !empty_c;
			idx_s1   <= 8'(col_q);
		end
		if (pend_s1) begin
			empty_res    <= empty_s1;
			last         <= last_s1;
			out_index    <= empty_s1 ? 8'd0 : idx_s1;
			out_position <= empty_s1 ? 6'd0 : 6'(pl_rdata);
			sum_value    <= empty_s1 ? 40'sd0 : r_rdata;
		end
	end

	assign res_valid = res_valid_q;

	`SRME_AST_NXT(a_read_yields_word, clk, arst_n, pend_s1, res_valid_q,
		"read did not produce a result word")
	`SRME_AST_IMP(a_empty_fields_zero, clk, arst_n, res_valid_q && empty_res,
		sum_value == 40'sd0 && !last && out_index == 8'd0 && out_position == 6'd0,
		"empty result word carries data")
	`SRME_AST_IMP(a_one_result_write, clk, arst_n, 1'b1, $onehot0(res_we_v),
		"two cells wrote results in one cycle")
endmodule
